FILE: src/wpas_pkg.sv
// Shared types and constants for the waypoint advance sequencer.
// Used by every module in src; depends on nothing else.
package wpas_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int COORD_W = 24;
    localparam int TRIG_W  = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int ACC_W   = SQ_W + 2;

    // Request type codes.
    localparam logic [1:0] REQ_POSE  = 2'd0;
    localparam logic [1:0] REQ_POINT = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Event codes of a result.
    localparam logic EVT_GOAL = 1'b0;
    localparam logic EVT_DROP = 1'b1;

    // Acceptance radius after reset, in millimeters.
    localparam logic [TRIG_W-1:0] TRIG_RESET = 16'd100;

    typedef struct packed {
        logic        [1:0]         req_type;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      new_trajectory;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] goal_x;
        logic signed [COORD_W-1:0] goal_y;
        logic signed [COORD_W-1:0] goal_z;
        logic                      event_code;
    } out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    // Per-cell control of the queue row.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // Status of the distance unit.
    typedef struct packed {
        logic done;
        logic reached;
    } dist_stat_t;

endpackage

FILE: src/waypoint_advance_sequencer_core.sv
// Waypoint advance sequencer: top level with the control sequencer and the queue row.
// Depends on wpas_pkg, wpas_cell and wpas_dist.
//
// A pose update is taken with its transfer. A trajectory point that is queued goes
// through transfer and execute; one that is published or dropped goes through transfer,
// execute and publish. A timer tick with an empty queue ends with its transfer. Otherwise
// it waits on the distance unit, then publishes the next point when the goal is reached.
// The distance unit runs dx, dy, dz and the radius through one shared 24x24 squarer
// and then compares the sum against the squared radius. The pending points sit in a
// row of QUEUE_DEPTH cells; a new point is written into the first free cell and
// removing the oldest point shifts the whole row one place toward the head at once.
// A new input transfer is taken while a published result still waits on the output;
// only a second result waits for it.
// The radius register may be written only while the block is idle.
module waypoint_advance_sequencer_core
    import wpas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_wr_en,
    input  logic [TRIG_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIST,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    in_t               item_reg, item_next;
    point_t            pose_reg, pose_next;
    point_t            goal_reg, goal_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TRIG_W-1:0] trig_reg, trig_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              push;
    logic              shift;
    logic              dist_start;
    dist_stat_t        dist_st;
    point_t            in_pt;
    point_t            item_pt;
    point_t            cell_q [QUEUE_DEPTH];
    cell_ctl_t         cell_ctl [QUEUE_DEPTH];

    assign in_pt   = '{x: s_data.pos_x, y: s_data.pos_y, z: s_data.pos_z};
    assign item_pt = '{x: item_reg.pos_x, y: item_reg.pos_y, z: item_reg.pos_z};

    // Queue row: cell 0 is the head, a shift moves every cell one place toward it.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        point_t nbr;
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end
        assign cell_ctl[i].load  = push && (count_reg == CNT_W'(i));
        assign cell_ctl[i].shift = shift;
        wpas_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl[i]),
            .wr_data  (item_pt),
            .nbr_data (nbr),
            .q        (cell_q[i])
        );
    end

    // Distance unit works on the pose and goal held at the tick transfer.
    wpas_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dist_start),
        .pose    (pose_reg),
        .goal    (goal_reg),
        .trig    (trig_reg),
        .stat    (dist_st)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        pose_next    = pose_reg;
        goal_next    = goal_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        trig_next    = cfg_wr_en ? cfg_wr_data : trig_reg;
        push         = 1'b0;
        shift        = 1'b0;
        dist_start   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.req_type)
                        REQ_POSE: begin
                            pose_next = in_pt;
                        end
                        REQ_POINT: begin
                            item_next  = s_data;
                            state_next = ST_EXEC;
                        end
                        REQ_TICK: begin
                            if (count_reg != '0) begin
                                dist_start = 1'b1;
                                state_next = ST_DIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                if (item_reg.new_trajectory) begin
                    count_next = '0;
                    goal_next  = item_pt;
                    res_next   = '{goal_x: item_reg.pos_x, goal_y: item_reg.pos_y,
                                   goal_z: item_reg.pos_z, event_code: EVT_GOAL};
                    state_next = ST_EMIT;
                end else if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                    res_next   = '{goal_x: '0, goal_y: '0, goal_z: '0,
                                   event_code: EVT_DROP};
                    state_next = ST_EMIT;
                end else begin
                    push       = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_DIST: begin
                if (dist_st.done) begin
                    if (dist_st.reached) begin
                        goal_next  = cell_q[0];
                        res_next   = '{goal_x: cell_q[0].x, goal_y: cell_q[0].y,
                                       goal_z: cell_q[0].z, event_code: EVT_GOAL};
                        shift      = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pose_reg    <= '0;
            goal_reg    <= '0;
            count_reg   <= '0;
            trig_reg    <= TRIG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pose_reg    <= pose_next;
            goal_reg    <= goal_next;
            count_reg   <= count_next;
            trig_reg    <= trig_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The fill count never passes the queue depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // The head is only removed from a nonempty queue.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        shift |-> (count_reg != '0))
        else $error("pop from empty queue");

    // The distance unit only reports while the sequencer waits for it.
    a_dist_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_st.done |-> (state_reg == ST_DIST))
        else $error("distance result outside tick processing");

    // A drop event carries zero goal fields.
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.event_code == EVT_DROP)) |->
        (m_data.goal_x == '0 && m_data.goal_y == '0 && m_data.goal_z == '0))
        else $error("drop event with nonzero goal");

endmodule

FILE: src/wpas_cell.sv
// One storage cell of the point queue row.
// Depends on wpas_pkg for the point and control types.
module wpas_cell
    import wpas_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  point_t    wr_data,
    input  point_t    nbr_data,
    output point_t    q
);

    point_t data_reg;
    point_t data_next;

    // A load takes a new point; a shift takes the neighbor's point toward the head.
    always_comb begin
        data_next = data_reg;
        if (ctl.load) begin
            data_next = wr_data;
        end else if (ctl.shift) begin
            data_next = nbr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

FILE: src/wpas_dist.sv
// Squared distance check with one shared 24x24 squarer.
// Depends on wpas_pkg for widths and the status type.
module wpas_dist
    import wpas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  point_t            pose,
    input  point_t            goal,
    input  logic [TRIG_W-1:0] trig,
    output dist_stat_t        stat
);

    logic [COORD_W-1:0] ad_reg [3];
    logic [COORD_W-1:0] ad_next [3];
    logic [TRIG_W-1:0]  lim_reg;
    logic [SQ_W-1:0]    prod_reg;
    logic [SQ_W-1:0]    prod_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [2:0]         step_reg;
    logic [2:0]         step_next;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic               reached_reg;
    logic               reached_next;
    logic [COORD_W-1:0] op;

    // Absolute difference of two signed coordinates; it always fits in 24 bits.
    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    // Squarer operand: the three differences, then the radius.
    always_comb begin
        case (step_reg[1:0])
            2'd0:    op = ad_reg[0];
            2'd1:    op = ad_reg[1];
            2'd2:    op = ad_reg[2];
            default: op = {{(COORD_W - TRIG_W){1'b0}}, lim_reg};
        endcase
    end

    // Squares go through prod_reg one per cycle and are summed behind it.
    always_comb begin
        ad_next      = ad_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        reached_next = reached_reg;
        if (start) begin
            ad_next[0] = abs_diff(pose.x, goal.x);
            ad_next[1] = abs_diff(pose.y, goal.y);
            ad_next[2] = abs_diff(pose.z, goal.z);
            acc_next   = '0;
            step_next  = 3'd0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (step_reg == 3'd4) begin
                reached_next = acc_reg < {2'b00, prod_reg};
                done_next    = 1'b1;
                busy_next    = 1'b0;
            end else begin
                prod_next = op * op;
                if (step_reg != 3'd0) begin
                    acc_next = acc_reg + {2'b00, prod_reg};
                end
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        ad_reg      <= ad_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        reached_reg <= reached_next;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lim_reg <= trig;
        end
    end

    assign stat.done    = done_reg;
    assign stat.reached = reached_reg;

endmodule
